// File: sv/adc_pedestal_accumulator_unit_defines.svh
// Assertion macros shared by the pedestal accumulator RTL.
`ifndef ADC_PEDESTAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define ADC_PEDESTAL_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/apa_pkg.sv
// Shared types and constants of the pedestal accumulator.
`default_nettype none

package apa_pkg;

  // Fixed field widths.
  localparam int PADDLE_W  = 6;
  localparam int LIM_W     = 14;
  localparam int PED_W     = 17;
  localparam int THR_W     = 18;
  localparam int CNT_OUT_W = 16;
  localparam int SQ_W      = 42;
  localparam int EVT_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int THRESH_W  = 14;
  localparam int PED_FRAC  = 4;

  // Arithmetic constants.
  localparam logic [LIM_W-1:0] LIM_MAX      = '1;
  localparam int               LIMIT_OFFSET = 100;
  localparam int               THR_OFFSET   = 15 << PED_FRAC;
  localparam int               PED_DIVISOR  = 5;
  // x / 5 == (x * 52429) >> 18 for every 16-bit x.
  localparam int               DIV5_MUL     = 52429;
  localparam int               DIV5_SHIFT   = 18;

  // Reset values of the configuration registers.
  localparam int                  MIN_PEDS_RST   = 500;
  localparam logic [LIM_W-1:0]    INIT_LIMIT_RST = LIM_W'(1000);
  localparam logic [THRESH_W-1:0] THRESH_RST     = THRESH_W'(MIN_PEDS_RST / PED_DIVISOR);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEDS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LIMIT = 1'b1;

  // Item actions and result status codes.
  localparam logic ACT_ACCUM  = 1'b0;
  localparam logic ACT_REPORT = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_RANGE   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: sv/apa_div.sv
// Shared unsigned divider, two restoring steps per cycle.
`default_nettype none

module apa_div #(
  parameter int DVD_W = 33,
  parameter int DSR_W = 16,
  parameter int QUO_W = 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DSR_W-1:0]     divisor,
  output apa_pkg::div_stat_t   stat,
  output logic [QUO_W-1:0]     quotient
);
  import apa_pkg::*;

  localparam int STEPS = QUO_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DSR_W:0]   t1;
  logic [DSR_W:0]   t2;
  logic             ge1;
  logic             ge2;
  logic [DSR_W-1:0] r1;
  logic [DSR_W-1:0] r2;
  logic [QUO_W-1:0] q1;
  logic [QUO_W-1:0] q2;

  // The caller guarantees the quotient fits in QUO_W bits, so the upper
  // dividend bits start below the divisor and the remainder never overflows.
  always_comb begin
    t1  = {rem_r, quo_r[QUO_W-1]};
    ge1 = t1 >= {1'b0, dsr_r};
    r1  = ge1 ? DSR_W'(t1 - {1'b0, dsr_r}) : t1[DSR_W-1:0];
    q1  = {quo_r[QUO_W-2:0], ge1};
    t2  = {r1, q1[QUO_W-1]};
    ge2 = t2 >= {1'b0, dsr_r};
    r2  = ge2 ? DSR_W'(t2 - {1'b0, dsr_r}) : t2[DSR_W-1:0];
    q2  = {q1[QUO_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DSR_W'(dividend >> QUO_W);
      quo_r <= dividend[QUO_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= r2;
      quo_r <= q2;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// File: sv/apa_ram.sv
// Single-port-write, registered-read memory for the per-paddle records.
`default_nettype none

module apa_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 202
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/adc_pedestal_accumulator_unit.sv
// Top level of the per-paddle ADC pedestal accumulator.
//
// Channel  Ports                                   Role
// in       in_valid, in_ready, in_* fields         item sink
// out      out_valid, out_ready, out_* fields      result source
// cfg      cfg_we, cfg_index, cfg_wdata            register writes
//
// Items are handled one at a time by a small sequencer around one record
// memory and one shared divider that retires two quotient bits per cycle.
// An accumulate word steps through load, update, write-back and done, with a
// divider start and run before write-back for each side whose limit tightens;
// a report word runs the divider once per side after load, then goes to done.
// An out-of-range paddle goes straight to done. Reset is synchronous; valid bits
// stand in for clearing the memory, so no clearing pass is needed.
// A stalled result waits in the output register; the next word is accepted
// meanwhile and holds in its final state until the register frees up.
`default_nettype none

module adc_pedestal_accumulator_unit #(
  parameter int NUM_ELEMENTS = 32,
  parameter int ADC_BITS     = 13,
  parameter int COUNT_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [apa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apa_pkg::CFG_W-1:0]         cfg_wdata,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [apa_pkg::PADDLE_W-1:0]      in_paddle,
  input  logic [ADC_BITS-1:0]               in_adc_pos,
  input  logic [ADC_BITS-1:0]               in_adc_neg,
  input  logic                              in_event_end,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_status,
  output logic [apa_pkg::PED_W-1:0]         out_pos_pedestal,
  output logic [apa_pkg::PED_W-1:0]         out_neg_pedestal,
  output logic [apa_pkg::THR_W-1:0]         out_pos_threshold,
  output logic [apa_pkg::THR_W-1:0]         out_neg_threshold,
  output logic [apa_pkg::CNT_OUT_W-1:0]     out_pos_count,
  output logic [apa_pkg::CNT_OUT_W-1:0]     out_neg_count,
  output logic [apa_pkg::SQ_W-1:0]          out_pos_sum_squares,
  output logic [apa_pkg::SQ_W-1:0]          out_neg_sum_squares,
  output logic [apa_pkg::EVT_W-1:0]         out_event_total
);
  import apa_pkg::*;

  `include "adc_pedestal_accumulator_unit_defines.svh"

  localparam int IDX_W  = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int SUM_W  = ADC_BITS + COUNT_BITS;
  localparam int DVD_W  = SUM_W + PED_FRAC;
  localparam int QUO_W  = 2 * ((ADC_BITS + PED_FRAC + 1) / 2);
  localparam int CMP_W  = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
  localparam int LCMP_W = (ADC_BITS > LIM_W) ? ADC_BITS : LIM_W;
  localparam int MX_W   = ((QUO_W > LIM_W) ? QUO_W : LIM_W) + 1;
  localparam int PX_W   = ((QUO_W > THR_W) ? QUO_W : THR_W) + 1;
  localparam int SQR_W  = 2 * ADC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DGO  = 3'd3;
  localparam logic [2:0] S_DRUN = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  typedef struct packed {
    logic [LIM_W-1:0]      lim;
    logic [COUNT_BITS-1:0] cnt;
    logic [SUM_W-1:0]      sum;
    logic [SQ_W-1:0]       sq;
  } side_t;

  typedef struct packed {
    side_t pos;
    side_t neg;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Adds one sample to a side unless it is above the limit or the count
  // has saturated.
  function automatic side_t add_side(side_t s, logic [ADC_BITS-1:0] adc,
                                     logic [SQR_W-1:0] sq);
    side_t o;
    o = s;
    if ((LCMP_W'(adc) <= LCMP_W'(s.lim)) && !(&s.cnt)) begin
      o.sum = s.sum + SUM_W'(adc);
      o.sq  = s.sq + SQ_W'(sq);
      o.cnt = s.cnt + 1'b1;
    end
    return o;
  endfunction

  // Control state
  logic [2:0]              state_r;
  logic [2:0]              state_nxt;
  logic                    out_valid_r;
  logic [NUM_ELEMENTS-1:0] data_vld_r;
  logic [NUM_ELEMENTS-1:0] lim_vld_r;
  logic [EVT_W-1:0]        evt_cnt_r;
  logic [THRESH_W-1:0]     thresh_r;
  logic [LIM_W-1:0]        init_limit_r;
  logic                    need_pos_r;
  logic                    need_neg_r;

  // Item and working payload
  logic                    act_r;
  logic                    bad_r;
  logic                    evend_r;
  logic [IDX_W-1:0]        idx_r;
  logic [ADC_BITS-1:0]     apos_r;
  logic [ADC_BITS-1:0]     aneg_r;
  logic [SQR_W-1:0]        sqp_r;
  logic [SQR_W-1:0]        sqn_r;
  side_t                   w_pos_r;
  side_t                   w_neg_r;
  logic [QUO_W-1:0]        ped_pos_r;
  logic [QUO_W-1:0]        ped_neg_r;

  // Result register
  logic                    out_status_r;
  logic [PED_W-1:0]        out_pos_ped_r;
  logic [PED_W-1:0]        out_neg_ped_r;
  logic [THR_W-1:0]        out_pos_thr_r;
  logic [THR_W-1:0]        out_neg_thr_r;
  logic [CNT_OUT_W-1:0]    out_pos_cnt_r;
  logic [CNT_OUT_W-1:0]    out_neg_cnt_r;
  logic [SQ_W-1:0]         out_pos_sq_r;
  logic [SQ_W-1:0]         out_neg_sq_r;
  logic [EVT_W-1:0]        out_evt_r;

  logic                    in_fire;
  logic                    out_fire;
  logic                    done_go;
  logic                    in_bad;
  logic [IDX_W-1:0]        in_idx;
  logic [2*CFG_W-1:0]      div5_prod;

  rec_t                    rd_rec;
  side_t                   ld_pos;
  side_t                   ld_neg;
  side_t                   up_pos;
  side_t                   up_neg;
  logic                    hit_pos;
  logic                    hit_neg;

  logic                    div_start;
  side_t                   div_src;
  logic [DVD_W-1:0]        div_dividend;
  logic [COUNT_BITS-1:0]   div_divisor;
  div_stat_t               div_stat;
  logic [QUO_W-1:0]        div_quo;
  logic [MX_W-1:0]         mean_ext;
  logic [LIM_W-1:0]        new_lim;
  logic [PX_W-1:0]         pos_px;
  logic [PX_W-1:0]         neg_px;
  logic [PX_W-1:0]         pos_thr;
  logic [PX_W-1:0]         neg_thr;
  logic [REC_W-1:0]        ram_rdata;
  logic                    rep_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign done_go  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign in_bad = (in_paddle == '0) ||
                  ((PADDLE_W + 1)'(in_paddle) > (PADDLE_W + 1)'(NUM_ELEMENTS));
  assign in_idx = IDX_W'(in_paddle - 1'b1);

  assign div5_prod = cfg_wdata * CFG_W'(DIV5_MUL);

  apa_ram #(
    .DEPTH (NUM_ELEMENTS),
    .AW    (IDX_W),
    .DW    (REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == S_WB),
    .waddr (idx_r),
    .wdata ({w_pos_r, w_neg_r}),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // A never-written record reads as zero sums; a limit not written since
  // the last initial-limit load reads as that register.
  always_comb begin
    rd_rec = rec_t'(ram_rdata);
    ld_pos = rd_rec.pos;
    ld_neg = rd_rec.neg;
    if (!data_vld_r[idx_r]) begin
      ld_pos.cnt = '0;
      ld_pos.sum = '0;
      ld_pos.sq  = '0;
      ld_neg.cnt = '0;
      ld_neg.sum = '0;
      ld_neg.sq  = '0;
    end
    if (!lim_vld_r[idx_r]) begin
      ld_pos.lim = init_limit_r;
      ld_neg.lim = init_limit_r;
    end
  end

  always_comb begin
    up_pos  = add_side(w_pos_r, apos_r, sqp_r);
    up_neg  = add_side(w_neg_r, aneg_r, sqn_r);
    hit_pos = (up_pos.cnt != w_pos_r.cnt) &&
              (CMP_W'(up_pos.cnt) == CMP_W'(thresh_r));
    hit_neg = (up_neg.cnt != w_neg_r.cnt) &&
              (CMP_W'(up_neg.cnt) == CMP_W'(thresh_r));
  end

  // The positive side is always served first.
  always_comb begin
    div_start = (state_r == S_DGO);
    div_src   = need_pos_r ? w_pos_r : w_neg_r;
    if (act_r == ACT_REPORT) begin
      div_dividend = {div_src.sum, {PED_FRAC{1'b0}}};
      div_divisor  = (div_src.cnt == '0) ? COUNT_BITS'(1) : div_src.cnt;
    end else begin
      div_dividend = DVD_W'(div_src.sum);
      div_divisor  = div_src.cnt;
    end
  end

  apa_div #(
    .DVD_W (DVD_W),
    .DSR_W (COUNT_BITS),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_comb begin
    mean_ext = MX_W'(div_quo) + MX_W'(LIMIT_OFFSET);
    new_lim  = (mean_ext > MX_W'(LIM_MAX)) ? LIM_MAX : mean_ext[LIM_W-1:0];
    pos_px   = PX_W'(ped_pos_r);
    neg_px   = PX_W'(ped_neg_r);
    pos_thr  = pos_px + PX_W'(THR_OFFSET);
    neg_thr  = neg_px + PX_W'(THR_OFFSET);
    rep_ok   = (act_r == ACT_REPORT) && !bad_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_bad ? S_DONE : S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = (act_r == ACT_REPORT) ? S_DGO : S_UPD;
      end
      S_UPD: begin
        state_nxt = (hit_pos || hit_neg) ? S_DGO : S_WB;
      end
      S_DGO: begin
        state_nxt = S_DRUN;
      end
      S_DRUN: begin
        if (div_stat.done) begin
          if (need_pos_r && need_neg_r) begin
            state_nxt = S_DGO;
          end else begin
            state_nxt = (act_r == ACT_REPORT) ? S_DONE : S_WB;
          end
        end
      end
      S_WB: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      data_vld_r   <= '0;
      lim_vld_r    <= '0;
      evt_cnt_r    <= '0;
      thresh_r     <= THRESH_RST;
      init_limit_r <= INIT_LIMIT_RST;
      need_pos_r   <= 1'b0;
      need_neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_LOAD) begin
        need_pos_r <= (act_r == ACT_REPORT);
        need_neg_r <= (act_r == ACT_REPORT);
      end else if (state_r == S_UPD) begin
        need_pos_r <= hit_pos;
        need_neg_r <= hit_neg;
      end else if ((state_r == S_DRUN) && div_stat.done) begin
        if (need_pos_r) begin
          need_pos_r <= 1'b0;
        end else begin
          need_neg_r <= 1'b0;
        end
      end

      if (state_r == S_WB) begin
        data_vld_r[idx_r] <= 1'b1;
        lim_vld_r[idx_r]  <= 1'b1;
        if (evend_r) begin
          evt_cnt_r <= evt_cnt_r + 1'b1;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_PEDS: begin
            thresh_r <= div5_prod[DIV5_SHIFT +: THRESH_W];
          end
          CFG_INIT_LIMIT: begin
            init_limit_r <= cfg_wdata[LIM_W-1:0];
            lim_vld_r    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r   <= in_action;
      bad_r   <= in_bad;
      evend_r <= in_event_end;
      idx_r   <= in_idx;
      apos_r  <= in_adc_pos;
      aneg_r  <= in_adc_neg;
    end

    if (state_r == S_LOAD) begin
      w_pos_r <= ld_pos;
      w_neg_r <= ld_neg;
      sqp_r   <= apos_r * apos_r;
      sqn_r   <= aneg_r * aneg_r;
    end else if (state_r == S_UPD) begin
      w_pos_r <= up_pos;
      w_neg_r <= up_neg;
    end else if ((state_r == S_DRUN) && div_stat.done) begin
      if (act_r == ACT_REPORT) begin
        if (need_pos_r) begin
          ped_pos_r <= div_quo;
        end else begin
          ped_neg_r <= div_quo;
        end
      end else begin
        if (need_pos_r) begin
          w_pos_r.lim <= new_lim;
        end else begin
          w_neg_r.lim <= new_lim;
        end
      end
    end

    if (done_go) begin
      out_status_r  <= bad_r ? ST_RANGE : ST_OK;
      out_pos_ped_r <= rep_ok ? pos_px[PED_W-1:0] : '0;
      out_neg_ped_r <= rep_ok ? neg_px[PED_W-1:0] : '0;
      out_pos_thr_r <= rep_ok ? pos_thr[THR_W-1:0] : '0;
      out_neg_thr_r <= rep_ok ? neg_thr[THR_W-1:0] : '0;
      out_pos_cnt_r <= rep_ok ? CNT_OUT_W'(w_pos_r.cnt) : '0;
      out_neg_cnt_r <= rep_ok ? CNT_OUT_W'(w_neg_r.cnt) : '0;
      out_pos_sq_r  <= rep_ok ? w_pos_r.sq : '0;
      out_neg_sq_r  <= rep_ok ? w_neg_r.sq : '0;
      out_evt_r     <= evt_cnt_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_pos_pedestal    = out_pos_ped_r;
  assign out_neg_pedestal    = out_neg_ped_r;
  assign out_pos_threshold   = out_pos_thr_r;
  assign out_neg_threshold   = out_neg_thr_r;
  assign out_pos_count       = out_pos_cnt_r;
  assign out_neg_count       = out_neg_cnt_r;
  assign out_pos_sum_squares = out_pos_sq_r;
  assign out_neg_sum_squares = out_neg_sq_r;
  assign out_event_total     = out_evt_r;

  `APA_ASSERT_IMPL(a_div_start_idle, clk, rst_n, div_start, !div_stat.busy, "divider started while busy")
  `APA_ASSERT_IMPL(a_div_done_run, clk, rst_n, div_stat.done, state_r == S_DRUN, "divider result not awaited")
  `APA_ASSERT_IMPL(a_dgo_need, clk, rst_n, state_r == S_DGO, need_pos_r || need_neg_r, "division with no side pending")
  `APA_ASSERT_NEXT(a_evt_only_wb, clk, rst_n, state_r != S_WB, $stable(evt_cnt_r), "event count moved outside write-back")

endmodule

`default_nettype wire

// File: verif/apa_pedestal_checker.sv
`timescale 1ns / 1ps
// Checker for the pedestal accumulator: predicts every result word and compares it.
module apa_pedestal_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [apa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_action,
  input  logic [apa_pkg::PADDLE_W-1:0]  in_paddle,
  input  logic [12:0]                   in_adc_pos,
  input  logic [12:0]                   in_adc_neg,
  input  logic                          in_event_end,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_status,
  input  logic [apa_pkg::PED_W-1:0]     out_pos_pedestal,
  input  logic [apa_pkg::PED_W-1:0]     out_neg_pedestal,
  input  logic [apa_pkg::THR_W-1:0]     out_pos_threshold,
  input  logic [apa_pkg::THR_W-1:0]     out_neg_threshold,
  input  logic [apa_pkg::CNT_OUT_W-1:0] out_pos_count,
  input  logic [apa_pkg::CNT_OUT_W-1:0] out_neg_count,
  input  logic [apa_pkg::SQ_W-1:0]      out_pos_sum_squares,
  input  logic [apa_pkg::SQ_W-1:0]      out_neg_sum_squares,
  input  logic [apa_pkg::EVT_W-1:0]     out_event_total,
  output int                            mismatch_total,
  output int                            reports_pending
);
  import apa_pkg::*;

  localparam int NUM_PADDLES = 32;
  localparam int SAMPLE_W    = 13;
  localparam int TALLY_MAX   = 65535;
  localparam int SIDE_POS    = 0;
  localparam int SIDE_NEG    = 1;

  typedef struct packed {
    logic                 status;
    logic [PED_W-1:0]     ped_pos;
    logic [PED_W-1:0]     ped_neg;
    logic [THR_W-1:0]     thr_pos;
    logic [THR_W-1:0]     thr_neg;
    logic [CNT_OUT_W-1:0] cnt_pos;
    logic [CNT_OUT_W-1:0] cnt_neg;
    logic [SQ_W-1:0]      sq_pos;
    logic [SQ_W-1:0]      sq_neg;
    logic [EVT_W-1:0]     events;
  } ped_word_t;

  logic [63:0]      sum_acc      [2][NUM_PADDLES];
  logic [63:0]      sq_acc       [2][NUM_PADDLES];
  int unsigned      tally        [2][NUM_PADDLES];
  logic [LIM_W-1:0] accept_limit [2][NUM_PADDLES];
  logic [EVT_W-1:0] event_count;
  logic [15:0]      min_peds_r;
  logic [LIM_W-1:0] init_limit_r;
  ped_word_t        expected_words [$];

  function automatic void reload_limits();
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < NUM_PADDLES; i++)
        accept_limit[s][i] = init_limit_r;
  endfunction

  function automatic void take_sample(input int s, input int i, input logic [SAMPLE_W-1:0] adc);
    logic [63:0] mean;
    int unsigned tighten_at;
    if (adc > accept_limit[s][i] || tally[s][i] >= TALLY_MAX)
      return;
    sum_acc[s][i] += 64'(adc);
    sq_acc[s][i]  += 64'(adc) * 64'(adc);
    tally[s][i]++;
    tighten_at = min_peds_r / PED_DIVISOR;
    // When the tally reaches the threshold, the limit is set once from the running mean.
    if (tally[s][i] == tighten_at) begin
      mean = sum_acc[s][i] / 64'(tally[s][i]) + 64'(LIMIT_OFFSET);
      accept_limit[s][i] = (mean > 64'(LIM_MAX)) ? LIM_MAX : mean[LIM_W-1:0];
    end
  endfunction

  function automatic logic [63:0] pedestal_sixteenths(input int s, input int i);
    int unsigned n;
    n = (tally[s][i] != 0) ? tally[s][i] : 1;
    return (sum_acc[s][i] << PED_FRAC) / 64'(n);
  endfunction

  function automatic ped_word_t predict_pedestal_word(input logic act,
                                                      input logic [PADDLE_W-1:0] pad,
                                                      input logic [SAMPLE_W-1:0] ap,
                                                      input logic [SAMPLE_W-1:0] an,
                                                      input logic ev);
    ped_word_t w;
    int i;
    logic [63:0] pp;
    logic [63:0] np;
    w = '0;
    if (pad == 0 || pad > NUM_PADDLES) begin
      w.status = ST_RANGE;
      w.events = event_count;
      return w;
    end
    i = pad - 1;
    if (act == ACT_ACCUM) begin
      take_sample(SIDE_POS, i, ap);
      take_sample(SIDE_NEG, i, an);
      if (ev)
        event_count++;
    end else begin
      pp = pedestal_sixteenths(SIDE_POS, i);
      np = pedestal_sixteenths(SIDE_NEG, i);
      w.ped_pos = pp[PED_W-1:0];
      w.ped_neg = np[PED_W-1:0];
      w.thr_pos = THR_W'(pp + 64'(THR_OFFSET));
      w.thr_neg = THR_W'(np + 64'(THR_OFFSET));
      w.cnt_pos = CNT_OUT_W'(tally[SIDE_POS][i]);
      w.cnt_neg = CNT_OUT_W'(tally[SIDE_NEG][i]);
      w.sq_pos  = SQ_W'(sq_acc[SIDE_POS][i]);
      w.sq_neg  = SQ_W'(sq_acc[SIDE_NEG][i]);
    end
    w.status = ST_OK;
    w.events = event_count;
    return w;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  initial begin
    mismatch_total  = 0;
    reports_pending = 0;
  end

  always @(posedge clk) begin : watch
    ped_word_t want;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < NUM_PADDLES; i++) begin
          sum_acc[s][i] = '0;
          sq_acc[s][i]  = '0;
          tally[s][i]   = 0;
        end
      event_count  = '0;
      min_peds_r   = 16'(MIN_PEDS_RST);
      init_limit_r = INIT_LIMIT_RST;
      reload_limits();
      expected_words.delete();
    end else begin
      // The result leaving now belongs to an earlier word, so it is checked first.
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatch_total++;
          $display("%0t: result word with no expectation waiting, expected none, got status %0d",
                   $time, out_status);
        end else begin
          want = expected_words.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("pos_pedestal", 64'(want.ped_pos), 64'(out_pos_pedestal));
          check_field("neg_pedestal", 64'(want.ped_neg), 64'(out_neg_pedestal));
          check_field("pos_threshold", 64'(want.thr_pos), 64'(out_pos_threshold));
          check_field("neg_threshold", 64'(want.thr_neg), 64'(out_neg_threshold));
          check_field("pos_count", 64'(want.cnt_pos), 64'(out_pos_count));
          check_field("neg_count", 64'(want.cnt_neg), 64'(out_neg_count));
          check_field("pos_sum_squares", 64'(want.sq_pos), 64'(out_pos_sum_squares));
          check_field("neg_sum_squares", 64'(want.sq_neg), 64'(out_neg_sum_squares));
          check_field("event_total", 64'(want.events), 64'(out_event_total));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_PEDS) begin
          min_peds_r = cfg_wdata;
        end else if (cfg_index == CFG_INIT_LIMIT) begin
          init_limit_r = cfg_wdata[LIM_W-1:0];
          reload_limits();
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(predict_pedestal_word(in_action, in_paddle, in_adc_pos,
                                                       in_adc_neg, in_event_end));
    end
    reports_pending = expected_words.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the pedestal accumulator: stimulus, flow control and verdict.
module tb_top;
  import apa_pkg::*;

  localparam int ADC_W        = 13;
  localparam int PADDLE_COUNT = 32;
  localparam int PAD_MAX      = 63;
  localparam int ADC_MAX      = 8191;
  localparam int LIMIT_TOP    = 8291;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 140;
  localparam int FILL_WORDS   = 8;
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [PADDLE_W-1:0]   in_paddle;
  logic [ADC_W-1:0]      in_adc_pos;
  logic [ADC_W-1:0]      in_adc_neg;
  logic                  in_event_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_status;
  logic [PED_W-1:0]      out_pos_pedestal;
  logic [PED_W-1:0]      out_neg_pedestal;
  logic [THR_W-1:0]      out_pos_threshold;
  logic [THR_W-1:0]      out_neg_threshold;
  logic [CNT_OUT_W-1:0]  out_pos_count;
  logic [CNT_OUT_W-1:0]  out_neg_count;
  logic [SQ_W-1:0]       out_pos_sum_squares;
  logic [SQ_W-1:0]       out_neg_sum_squares;
  logic [EVT_W-1:0]      out_event_total;
  int                    mismatch_total;
  int                    reports_pending;

  logic idle_on;
  int   stall_asks;

  adc_pedestal_accumulator_unit dut (.*);

  apa_pedestal_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #25_000_000;
    $display("adc_pedestal_accumulator_unit regression: fail");
    $finish;
  end

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    int stall_seen;
    stall_left = 0;
    stall_seen = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asks != stall_seen) begin
        stall_seen = stall_asks;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < 30);
      end
    end
  end

  task automatic send_word(input logic act, input logic [PADDLE_W-1:0] pad,
                           input logic [ADC_W-1:0] ap, input logic [ADC_W-1:0] an,
                           input logic ev);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_paddle    <= pad;
    in_adc_pos   <= ap;
    in_adc_neg   <= an;
    in_event_end <= ev;
    do
      @(posedge clk);
    while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (reports_pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A sample near the paddle's pedestal level, now and then a random value over the full range.
  function automatic logic [ADC_W-1:0] noisy_sample(input int level, input int spread);
    int v;
    v = level - spread + int'($urandom_range(0, 2 * spread));
    if ($urandom_range(0, 99) < 8)
      v = int'($urandom_range(0, ADC_MAX));
    if (v < 0)
      v = 0;
    if (v > ADC_MAX)
      v = ADC_MAX;
    return ADC_W'(v);
  endfunction

  initial begin : stimulus
    int level [4];
    int spread;
    int lim_now;
    int min_peds_now;
    int r;
    int k;
    int base;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MIN_PEDS;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_action    = ACT_ACCUM;
    in_paddle    = '0;
    in_adc_pos   = '0;
    in_adc_neg   = '0;
    in_event_end = 1'b0;
    idle_on      = 1'b1;
    stall_asks   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: empty paddles, out-of-range paddles, the default limit.
    send_word(ACT_REPORT, 6'd1, '0, '0, 1'b0);
    send_word(ACT_REPORT, 6'd0, '1, '1, 1'b1);
    send_word(ACT_ACCUM, 6'd0, 13'd5, 13'd5, 1'b1);
    send_word(ACT_ACCUM, 6'd33, '1, '1, 1'b1);
    send_word(ACT_ACCUM, 6'd63, '0, '0, 1'b1);
    send_word(ACT_ACCUM, 6'd1, '0, '0, 1'b1);
    send_word(ACT_ACCUM, 6'd32, 13'd1000, 13'd1000, 1'b0);
    send_word(ACT_ACCUM, 6'd32, 13'd1001, '1, 1'b1);
    send_word(ACT_REPORT, 6'd32, '0, '0, 1'b1);
    send_word(ACT_ACCUM, 6'd2, '1, '0, 1'b0);
    send_word(ACT_REPORT, 6'd1, '0, '0, 1'b0);

    // The limit tightens after two samples on each side.
    drain_results();
    write_reg(CFG_MIN_PEDS, 16'd10);
    write_reg(CFG_INIT_LIMIT, CFG_W'(LIMIT_TOP));
    send_word(ACT_ACCUM, 6'd3, 13'd500, 13'd600, 1'b0);
    send_word(ACT_ACCUM, 6'd3, 13'd700, 13'd0, 1'b1);
    send_word(ACT_ACCUM, 6'd3, 13'd701, 13'd401, 1'b0);
    send_word(ACT_ACCUM, 6'd3, 13'd700, 13'd400, 1'b0);
    send_word(ACT_REPORT, 6'd3, '0, '0, 1'b0);
    send_word(ACT_ACCUM, 6'd2, '1, '1, 1'b0);
    send_word(ACT_REPORT, 6'd2, '1, '1, 1'b0);

    // A zero limit reloads every paddle while its sums are kept.
    drain_results();
    write_reg(CFG_MIN_PEDS, 16'd4);
    write_reg(CFG_INIT_LIMIT, '0);
    send_word(ACT_ACCUM, 6'd4, 13'd0, 13'd1, 1'b0);
    send_word(ACT_ACCUM, 6'd3, 13'd0, 13'd5, 1'b1);
    send_word(ACT_REPORT, 6'd4, '0, '0, 1'b0);
    send_word(ACT_REPORT, 6'd3, '0, '0, 1'b0);
    send_word(ACT_REPORT, 6'd33, '0, '0, 1'b1);

    // Each phase works mostly on its own four paddles so that limits can tighten.
    lim_now = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == 0) begin
        min_peds_now = 65535;
        lim_now      = LIMIT_TOP;
      end else if (p == 1) begin
        min_peds_now = 0;
        lim_now      = 0;
      end else begin
        min_peds_now = $urandom_range(5, 100);
        if (p % 3 != 1)
          lim_now = $urandom_range(150, LIMIT_TOP);
      end
      write_reg(CFG_MIN_PEDS, CFG_W'(min_peds_now));
      if (p < 2 || p % 3 != 1)
        write_reg(CFG_INIT_LIMIT, CFG_W'(lim_now));
      idle_on <= (p != 3);
      for (int j = 0; j < 4; j++)
        level[j] = $urandom_range(0, (lim_now > ADC_MAX) ? ADC_MAX : lim_now);
      spread = $urandom_range(0, 40);
      base   = 4 * p + 1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 2 && n == 40)
          stall_asks <= stall_asks + 1;
        if (p == 4 && n == 70)
          drain_results();
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_word(1'($urandom_range(0, 1)), 6'($urandom_range(0, PAD_MAX)),
                    ADC_W'($urandom_range(0, ADC_MAX)), ADC_W'($urandom_range(0, ADC_MAX)),
                    1'($urandom_range(0, 1)));
        end else if (r < 28) begin
          send_word(ACT_REPORT, 6'(base + $urandom_range(0, 3)),
                    ADC_W'($urandom_range(0, ADC_MAX)), ADC_W'($urandom_range(0, ADC_MAX)),
                    1'($urandom_range(0, 1)));
        end else begin
          k = $urandom_range(0, 3);
          send_word(ACT_ACCUM, 6'(base + k), noisy_sample(level[k], spread),
                    noisy_sample(level[k], spread), $urandom_range(0, 99) < 25);
        end
      end
    end

    // A short burst of full-scale samples on the last paddle, no idling.
    drain_results();
    write_reg(CFG_MIN_PEDS, 16'hFFFF);
    write_reg(CFG_INIT_LIMIT, CFG_W'(LIMIT_TOP));
    idle_on <= 1'b0;
    repeat (FILL_WORDS)
      send_word(ACT_ACCUM, 6'(PADDLE_COUNT), '1, '1, 1'b1);
    send_word(ACT_REPORT, 6'(PADDLE_COUNT), '0, '0, 1'b0);
    idle_on <= 1'b1;
    send_word(ACT_REPORT, 6'(PADDLE_COUNT - 1), '1, '1, 1'b1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0)
      $display("adc_pedestal_accumulator_unit regression: pass");
    else
      $display("adc_pedestal_accumulator_unit regression: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/apa_pkg.sv
sv/apa_div.sv
sv/apa_ram.sv
sv/adc_pedestal_accumulator_unit.sv
verif/apa_pedestal_checker.sv
verif/tb_top.sv
